FILE: sv/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
`default_nettype none

package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;

    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int TOT_W   = 48;

    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int TBL_AW    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // bit accumulator: up to seven pending bits plus one full code, MSB aligned
    localparam int ACC_W = LEN_LIMIT + BYTE_W;
    localparam int N_W   = $clog2(ACC_W + 1);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCNT_W = QAW + 1;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    typedef enum logic {
        OP_ENCODE,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_tbl_ent;

    typedef struct packed {
        t_op               op;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_q_item;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: sv/hcbp_front.sv
// Front end: code table, command decode and table lookup stage.
`default_nettype none

module hcbp_front
    import hcbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [1:0]        i_command,
    input  wire logic [SYM_W-1:0]  i_symbol,
    input  wire logic [CODE_W-1:0] i_code_bits,
    input  wire logic [LEN_W-1:0]  i_code_length,
    input  wire t_q_stat           i_q_stat,
    output logic                   o_q_push,
    output t_q_item                o_q_item
);

    t_tbl_ent                 r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]  r_tbl_vld;
    t_tbl_ent                 r_ent;
    logic                     r_ent_vld;
    logic                     r_s1_vld;
    t_op                      r_s1_op;

    logic                     accept;
    logic                     in_table;
    logic [TBL_AW-1:0]        idx;
    logic [LEN_W-1:0]         len_sat;
    logic [CODE_W-1:0]        len_mask;
    logic                     tbl_we;
    logic                     tbl_re;
    t_tbl_ent                 wr_ent;

    assign o_full   = r_s1_vld ? (i_q_stat.count >= QCNT_W'(QDEPTH - 1))
                               : (i_q_stat.count >= QCNT_W'(QDEPTH));
    assign accept   = i_push && !o_full;
    assign in_table = ({1'b0, i_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign idx      = i_symbol[TBL_AW-1:0];

    assign len_sat  = (i_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : i_code_length;
    assign len_mask = (len_sat >= LEN_W'(CODE_W)) ? '1
                                                  : ((CODE_W'(1) << len_sat) - CODE_W'(1));
    assign wr_ent.len  = len_sat;
    assign wr_ent.code = i_code_bits & len_mask;

    assign tbl_we = accept && in_table && (i_command == CMD_LOAD);
    assign tbl_re = accept && (i_command == CMD_ENCODE);

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_mem[idx] <= wr_ent;
        end
        if (tbl_re) begin
            r_ent <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
            r_ent_vld <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s1_op   <= OP_ENCODE;
        end else begin
            if (tbl_we) begin
                r_tbl_vld[idx] <= 1'b1;
            end
            r_s1_vld <= accept && (i_command inside {CMD_ENCODE, CMD_FLUSH});
            if (accept) begin
                case (i_command)
                    CMD_ENCODE: begin
                        r_s1_op   <= OP_ENCODE;
                        r_ent_vld <= r_tbl_vld[idx] && in_table;
                    end
                    CMD_FLUSH: begin
                        r_s1_op <= OP_FLUSH;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // entries never loaded read as zero-length codes
    assign o_q_push      = r_s1_vld;
    assign o_q_item.op   = r_s1_op;
    assign o_q_item.code = r_ent_vld ? r_ent.code : '0;
    assign o_q_item.len  = r_ent_vld ? r_ent.len : '0;

endmodule

`default_nettype wire

FILE: sv/hcbp_cmd_fifo.sv
// Short request queue between front end and packer.
`default_nettype none

module hcbp_cmd_fifo
    import hcbp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_q_item i_item,
    input  wire logic    i_pop,
    output t_q_item      o_item,
    output t_q_stat      o_stat
);

    t_q_item           r_mem [QDEPTH];
    logic [QAW-1:0]    r_wp;
    logic [QAW-1:0]    r_rp;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

    no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_cnt != QCNT_W'(QDEPTH)))
        else $error("request queue overflow");

    no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("request queue underflow");

endmodule

`default_nettype wire

FILE: sv/hcbp_back.sv
// Back end: bit accumulator, byte emission, bit counter and result register.
`default_nettype none

module hcbp_back
    import hcbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_q_item           i_q_item,
    input  wire t_q_stat           i_q_stat,
    output logic                   o_q_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_has_byte,
    output logic [TOT_W-1:0]       o_total_bits,
    output logic                   o_last
);

    logic [ACC_W-1:0]  r_acc;
    logic [N_W-1:0]    r_n;
    logic [TOT_W-1:0]  r_total;
    logic              r_ov;
    logic [BYTE_W-1:0] r_byte;
    logic              r_has;
    logic [TOT_W-1:0]  r_tot_out;
    logic              r_last;

    logic [ACC_W-1:0]  n_acc;
    logic [N_W-1:0]    n_n;
    logic [TOT_W-1:0]  n_total;
    logic              n_ov;
    logic [BYTE_W-1:0] n_byte;
    logic              n_has;
    logic [TOT_W-1:0]  n_tot_out;
    logic              n_last;

    logic              can_out;
    logic              q_pop;
    logic [N_W-1:0]    app_n;
    logic [N_W-1:0]    app_sh;
    logic [ACC_W-1:0]  app_acc;
    logic [TOT_W:0]    sum;

    assign can_out = !r_ov || i_pop;
    assign app_n   = r_n + N_W'(i_q_item.len);
    assign app_sh  = N_W'(ACC_W) - app_n;
    assign app_acc = r_acc | (ACC_W'(i_q_item.code) << app_sh);
    assign sum     = {1'b0, r_total} + (TOT_W + 1)'(i_q_item.len);

    always_comb begin
        n_acc     = r_acc;
        n_n       = r_n;
        n_total   = r_total;
        n_ov      = r_ov && !i_pop;
        n_byte    = r_byte;
        n_has     = r_has;
        n_tot_out = r_tot_out;
        n_last    = r_last;
        q_pop     = 1'b0;
        if (r_n >= N_W'(BYTE_W)) begin
            if (can_out) begin
                n_ov      = 1'b1;
                n_byte    = r_acc[ACC_W-1 -: BYTE_W];
                n_has     = 1'b1;
                n_tot_out = '0;
                n_last    = (r_n < N_W'(2 * BYTE_W));
                n_acc     = r_acc << BYTE_W;
                n_n       = r_n - N_W'(BYTE_W);
            end
        end else if (!i_q_stat.empty) begin
            case (i_q_item.op)
                OP_ENCODE: begin
                    q_pop   = 1'b1;
                    n_total = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
                    if (app_n >= N_W'(BYTE_W) && can_out) begin
                        n_ov      = 1'b1;
                        n_byte    = app_acc[ACC_W-1 -: BYTE_W];
                        n_has     = 1'b1;
                        n_tot_out = '0;
                        n_last    = (app_n < N_W'(2 * BYTE_W));
                        n_acc     = app_acc << BYTE_W;
                        n_n       = app_n - N_W'(BYTE_W);
                    end else begin
                        n_acc = app_acc;
                        n_n   = app_n;
                    end
                end
                OP_FLUSH: begin
                    if (can_out) begin
                        q_pop     = 1'b1;
                        n_ov      = 1'b1;
                        n_byte    = r_acc[ACC_W-1 -: BYTE_W];
                        n_has     = (r_n != '0);
                        n_tot_out = r_total;
                        n_last    = 1'b1;
                        n_acc     = '0;
                        n_n       = '0;
                        n_total   = '0;
                    end
                end
                default: begin
                    q_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_n     <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_n     <= n_n;
            r_total <= n_total;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_has     <= n_has;
        r_tot_out <= n_tot_out;
        r_last    <= n_last;
    end

    assign o_q_pop      = q_pop;
    assign o_empty      = !r_ov;
    assign o_out_byte   = r_byte;
    assign o_has_byte   = r_has;
    assign o_total_bits = r_tot_out;
    assign o_last       = r_last;

    acc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n < N_W'(ACC_W))
        else $error("accumulator bit count out of range");

    empty_flush_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_has) |-> (r_last && (r_byte == '0)))
        else $error("flush without pending bits carries a byte");

    count_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_tot_out != '0)) |-> r_last)
        else $error("bit count on a non-final result");

endmodule

`default_nettype wire

FILE: sv/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer.
//
//  channel   direction  handshake            payload
//  request   in         i_push / o_full      i_command, i_symbol, i_code_bits, i_code_length
//  result    out        o_empty / i_pop      o_out_byte, o_has_byte, o_total_bits, o_last
//
// One request is taken per cycle while full is low; loads finish in the front end, encodes
// and flushes reach the packer through the front-end stage register and a four-entry queue.
// The packer takes one queued request at a time and emits any further bytes of an encode
// before the next; the single result register paces byte output to one per cycle while popped.
// Reset marks every table entry empty at once (per-entry valid flops), no clearing pass.
// Either side may stall freely; full rises once the queue, counting any staged request, has no room left.
`default_nettype none

module huffman_code_bit_packer
    import hcbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [1:0]        i_command,
    input  wire logic [SYM_W-1:0]  i_symbol,
    input  wire logic [CODE_W-1:0] i_code_bits,
    input  wire logic [LEN_W-1:0]  i_code_length,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_has_byte,
    output logic [TOT_W-1:0]       o_total_bits,
    output logic                   o_last
);

    t_q_stat q_stat;
    t_q_item q_wr_item;
    t_q_item q_rd_item;
    logic    q_push;
    logic    q_pop;

    hcbp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_command     (i_command),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .i_q_stat      (q_stat),
        .o_q_push      (q_push),
        .o_q_item      (q_wr_item)
    );

    hcbp_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_wr_item),
        .i_pop   (q_pop),
        .o_item  (q_rd_item),
        .o_stat  (q_stat)
    );

    hcbp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_item     (q_rd_item),
        .i_q_stat     (q_stat),
        .o_q_pop      (q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_out_byte   (o_out_byte),
        .o_has_byte   (o_has_byte),
        .o_total_bits (o_total_bits),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
